[sv/pn4_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pn4_pkg
// Shared types and constants of the 4-D gradient noise block.
// ---------------------------------------------------------------------------
package pn4_pkg;

    typedef enum logic [0:0] {
        MODE_EVAL = 1'b0,
        MODE_LOAD = 1'b1
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FADE = 4'b0010,
        S_LOOK = 4'b0100,
        S_LERP = 4'b1000
    } back_state_t;

    // Gradient component codes
    typedef logic [1:0] gsign_t;
    localparam gsign_t G_POS = 2'b01;
    localparam gsign_t G_NEG = 2'b11;

    localparam int NUM_AXES    = 4;
    localparam int NUM_CORNERS = 16;
    localparam int PERM_W      = 8;
    localparam int GRAD_IDX_W  = 5;

    // Fade polynomial 6f^5 - 15f^4 + 10f^3
    localparam int FADE_A = 6;
    localparam int FADE_B = 15;
    localparam int FADE_C = 10;

    // Each entry holds {gx, gy, gz, gt}, two bits per component
    localparam logic [7:0] GRAD_ROM [32] = '{
        8'b01010100, 8'b01010001, 8'b01000101, 8'b00010101,
        8'b01011100, 8'b01010011, 8'b01000111, 8'b00010111,
        8'b01110100, 8'b01110001, 8'b01001101, 8'b00011101,
        8'b01111100, 8'b01110011, 8'b01001111, 8'b00011111,
        8'b11010100, 8'b11010001, 8'b11000101, 8'b00110101,
        8'b11011100, 8'b11010011, 8'b11000111, 8'b00110111,
        8'b11110100, 8'b11110001, 8'b11001101, 8'b00111101,
        8'b11111100, 8'b11110011, 8'b11001111, 8'b00111111
    };

endpackage
`default_nettype wire

[sv/pn4_ram.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pn4_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pn4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[sv/pn4_fifo.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pn4_fifo
// Short register queue between the front and the back.
// ---------------------------------------------------------------------------
module pn4_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output logic      [WIDTH-1:0] rd_data
);
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    ast_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");
    ast_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !valid |-> !pop)
        else $error("queue read while empty");
    ast_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not advance");
endmodule
`default_nettype wire

[sv/pn4_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pn4_front
// Accepts items, splits coordinates into cell corner and fraction,
// and packs the word for the queue.
// ---------------------------------------------------------------------------
module pn4_front #(
    parameter int FRAC_BITS = 16,
    parameter int IDX_W     = 8,
    parameter int ITEM_W    = 1 + 8 + 5*8 + 4*16
) (
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic              mode,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    input  wire logic signed [31:0] coord_z,
    input  wire logic signed [31:0] coord_t,
    input  wire logic [7:0]        entry_index,
    input  wire logic [7:0]        entry_value,
    output logic                   push,
    output logic [ITEM_W-1:0]      item
);
    import pn4_pkg::*;

    logic signed [31:0]   coord    [NUM_AXES];
    logic signed [63:0]   ext      [NUM_AXES];
    logic [IDX_W-1:0]     cell_idx [NUM_AXES];
    logic [FRAC_BITS-1:0] frac     [NUM_AXES];
    logic [IDX_W-1:0]     eidx;
    mode_t                kind;

    assign coord[0] = coord_x;
    assign coord[1] = coord_y;
    assign coord[2] = coord_z;
    assign coord[3] = coord_t;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            // floor of a signed fixed-point value is its integer bits
            ext[a]      = {{32{coord[a][31]}}, coord[a]};
            cell_idx[a] = ext[a][FRAC_BITS +: IDX_W];
            frac[a]     = coord[a][FRAC_BITS-1:0];
        end
        eidx = IDX_W'({{IDX_W{1'b0}}, entry_index});
        kind = mode_t'(mode);
    end

    assign push = start && !busy;
    assign item = {kind == MODE_LOAD, entry_value, eidx,
                   cell_idx[3], cell_idx[2], cell_idx[1], cell_idx[0],
                   frac[3], frac[2], frac[1], frac[0]};
endmodule
`default_nettype wire

[sv/pn4_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// pn4_back
// Executes queued words: table loads, and noise evaluation through fade,
// permutation lookup with gradient dot, and multilinear blend.
// ---------------------------------------------------------------------------
module pn4_back #(
    parameter int FRAC_BITS = 16,
    parameter int IDX_W     = 8,
    parameter int ITEM_W    = 1 + 8 + 5*8 + 4*16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [ITEM_W-1:0]        item,
    output logic                          pop,
    output logic                          ram_we,
    output logic [IDX_W-1:0]              ram_waddr,
    output logic [7:0]                    ram_wdata,
    output logic [IDX_W-1:0]              ram_raddr,
    input  wire logic [7:0]               ram_rdata,
    output logic                          done,
    output logic signed [FRAC_BITS+2:0]   noise_value
);
    import pn4_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int VW = F + 4;
    localparam int PW = 2*F + 6;
    localparam logic signed [F:0]    ONE_O  = (F+1)'(longint'(1) << F);
    localparam logic signed [F+5:0]  ONE_P  = (F+6)'(longint'(1) << F);
    localparam logic signed [VW-1:0] SAT_HI = VW'(3 * (longint'(1) << F));
    localparam logic signed [VW-1:0] SAT_LO = -SAT_HI;

    // control
    back_state_t state_reg, state_next;
    logic [1:0]  axis_reg, axis_next;
    logic [1:0]  fstep_reg, fstep_next;
    logic [6:0]  look_reg, look_next;
    logic [1:0]  lv_reg, lv_next;
    logic [3:0]  k_reg, k_next;
    logic        s1_valid_reg, s1_valid_next;
    logic        s2_valid_reg, s2_valid_next;
    logic        done_reg, done_next;

    // datapath
    logic [IDX_W-1:0]      cell_reg [NUM_AXES];
    logic [F-1:0]          frac_reg [NUM_AXES];
    logic [F-1:0]          q2_reg, q3_reg;
    logic [F+3:0]          p_reg;
    logic [F:0]            w_reg [NUM_AXES];
    logic signed [VW-1:0]  v_reg [NUM_CORNERS];
    logic signed [VW-1:0]  r_reg [8];
    logic signed [VW-1:0]  a1_reg, d1_reg, a2_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [F+2:0]   noise_reg;

    logic                  is_load;
    logic [F-1:0]          f_cur;
    logic [2*F-1:0]        ff_prod, qf_prod;
    logic [2*F+3:0]        wp_prod;
    logic signed [F+5:0]   p_calc;
    logic [1:0]            level;
    logic [3:0]            corner, pcorner;
    logic                  sel_bit;
    logic [IDX_W-1:0]      h_ext;
    logic                  dot_ready;
    logic [7:0]            grad;
    logic signed [F:0]     off [NUM_AXES];
    logic signed [VW-1:0]  dot;
    logic [3:0]            n_lv;
    logic                  issue, lv_end;
    logic signed [VW-1:0]  blend, sat_val;

    assign is_load   = item[ITEM_W-1];
    assign pop       = (state_reg == S_IDLE) && in_valid;
    assign ram_we    = pop && is_load;
    assign ram_waddr = item[4*F + 4*IDX_W +: IDX_W];
    assign ram_wdata = item[4*F + 5*IDX_W +: 8];

    // fade arithmetic
    always_comb
    begin
        f_cur   = frac_reg[axis_reg];
        ff_prod = f_cur * f_cur;
        qf_prod = q2_reg * f_cur;
        p_calc  = $signed({6'b0, q2_reg}) * $signed((F+6)'(FADE_A))
                - $signed({6'b0, f_cur}) * $signed((F+6)'(FADE_B))
                + ONE_P * $signed((F+6)'(FADE_C));
        wp_prod = q3_reg * p_reg;
    end

    // lookup chain: one dependent table read per cycle
    always_comb
    begin
        level   = look_reg[1:0];
        corner  = look_reg[5:2];
        pcorner = corner - 4'd1;
        sel_bit = corner[2'd3 - level];
        h_ext   = IDX_W'({{IDX_W{1'b0}}, ram_rdata});
        ram_raddr = cell_reg[level] + IDX_W'(sel_bit)
                  + ((level == 2'd0) ? '0 : h_ext);
        dot_ready = (state_reg == S_LOOK) && (level == 2'd0) && (look_reg != '0);
        grad = GRAD_ROM[ram_rdata[GRAD_IDX_W-1:0]];
        dot  = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            off[a] = pcorner[3-a] ? ($signed({1'b0, frac_reg[a]}) - ONE_O)
                                  : $signed({1'b0, frac_reg[a]});
            if (grad[7-2*a -: 2] == G_POS)
            begin
                dot = dot + VW'(off[a]);
            end
            else if (grad[7-2*a -: 2] == G_NEG)
            begin
                dot = dot - VW'(off[a]);
            end
        end
    end

    // blend pipeline control
    always_comb
    begin
        n_lv   = 4'd8 >> lv_reg;
        issue  = (state_reg == S_LERP) && (k_reg < n_lv);
        lv_end = (state_reg == S_LERP) && (k_reg == n_lv + 4'd2);
        blend  = a2_reg + VW'(prod_reg >>> F);
        if (r_reg[7] > SAT_HI)
        begin
            sat_val = SAT_HI;
        end
        else if (r_reg[7] < SAT_LO)
        begin
            sat_val = SAT_LO;
        end
        else
        begin
            sat_val = r_reg[7];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        fstep_next    = fstep_reg;
        look_next     = look_reg;
        lv_next       = lv_reg;
        k_next        = k_reg;
        done_next     = 1'b0;
        s1_valid_next = issue;
        s2_valid_next = s1_valid_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop && !is_load)
                begin
                    state_next = S_FADE;
                    axis_next  = '0;
                    fstep_next = '0;
                end
            end
            S_FADE:
            begin
                fstep_next = fstep_reg + 2'd1;
                if (fstep_reg == 2'd2)
                begin
                    fstep_next = '0;
                    axis_next  = axis_reg + 2'd1;
                    if (axis_reg == 2'd3)
                    begin
                        state_next = S_LOOK;
                        look_next  = '0;
                    end
                end
            end
            S_LOOK:
            begin
                look_next = look_reg + 7'd1;
                if (look_reg == 7'(4*NUM_CORNERS))
                begin
                    state_next = S_LERP;
                    lv_next    = '0;
                    k_next     = '0;
                end
            end
            S_LERP:
            begin
                k_next = k_reg + 4'd1;
                if (lv_end)
                begin
                    k_next = '0;
                    if (lv_reg == 2'd3)
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        lv_next = lv_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            axis_reg     <= '0;
            fstep_reg    <= '0;
            look_reg     <= '0;
            lv_reg       <= '0;
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            axis_reg     <= axis_next;
            fstep_reg    <= fstep_next;
            look_reg     <= look_next;
            lv_reg       <= lv_next;
            k_reg        <= k_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !is_load)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                cell_reg[a] <= item[4*F + a*IDX_W +: IDX_W];
                frac_reg[a] <= item[a*F +: F];
            end
        end

        if (state_reg == S_FADE)
        begin
            unique case (fstep_reg)
                2'd0: q2_reg <= ff_prod[2*F-1:F];
                2'd1:
                begin
                    q3_reg <= qf_prod[2*F-1:F];
                    p_reg  <= p_calc[F+3:0];
                end
                default: w_reg[axis_reg] <= wp_prod[2*F:F];
            endcase
        end

        // shift corner values in, corner 0 ends at the head
        if (dot_ready)
        begin
            for (int i = 0; i < NUM_CORNERS-1; i++)
            begin
                v_reg[i] <= v_reg[i+1];
            end
            v_reg[NUM_CORNERS-1] <= dot;
        end
        else if (issue)
        begin
            for (int i = 0; i < NUM_CORNERS-2; i++)
            begin
                v_reg[i] <= v_reg[i+2];
            end
        end
        else if (lv_end)
        begin
            unique case (lv_reg)
                2'd0: for (int i = 0; i < 8; i++) v_reg[i] <= r_reg[i];
                2'd1: for (int i = 0; i < 4; i++) v_reg[i] <= r_reg[4+i];
                2'd2: for (int i = 0; i < 2; i++) v_reg[i] <= r_reg[6+i];
                default: noise_reg <= (F+3)'(sat_val);
            endcase
        end

        if (issue)
        begin
            a1_reg <= v_reg[0];
            d1_reg <= v_reg[1] - v_reg[0];
        end
        if (s1_valid_reg)
        begin
            a2_reg   <= a1_reg;
            prod_reg <= PW'(d1_reg) * PW'($signed({1'b0, w_reg[~lv_reg]}));
        end
        if (s2_valid_reg)
        begin
            for (int i = 0; i < 7; i++)
            begin
                r_reg[i] <= r_reg[i+1];
            end
            r_reg[7] <= blend;
        end
    end

    assign done        = done_reg;
    assign noise_value = noise_reg;

    ast_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("two results in a row");
    ast_no_write_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_IDLE)
        else $error("table written during evaluation");
    ast_look_to_blend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK && look_reg == 7'(4*NUM_CORNERS)) |=> state_reg == S_LERP)
        else $error("lookup did not hand over to blend");
    ast_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (VW'(noise_value) <= SAT_HI) && (VW'(noise_value) >= SAT_LO))
        else $error("result out of range");
endmodule
`default_nettype wire

[sv/perlin_noise_4d_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// perlin_noise_4d_top
// Four-dimensional gradient noise with a loadable permutation table.
// ---------------------------------------------------------------------------
// Usage:
//   Drive mode and the payload ports and raise start; a word is taken at a
//   rising edge with start high and busy low. mode 0 evaluates noise at
//   (coord_x, coord_y, coord_z, coord_t) in signed Q16.16; mode 1 writes
//   entry_value into the permutation table at entry_index and gives no result.
//   Load the whole table before the first evaluation.
//   Words land in a four-deep queue; busy is high only while it is full.
//   A load is written to the table once it is at the queue head and the back
//   end is idle. An evaluation holds the back end while it is taken from the
//   queue, computes the fade weights (three multiplies per axis), makes the
//   chained table reads (one read port, 4 dependent reads for each of 16
//   corners plus one to finish the last) and runs the blend pipeline.
//   Loads are taken one per cycle while no evaluation holds the back end.
//   The result shows on noise_value with done high for exactly one cycle;
//   the receiver cannot stall and must take it then.
//   Reset clears the queue and the sequencer; the table holds garbage until
//   loaded.
// ---------------------------------------------------------------------------
module perlin_noise_4d_top #(
    parameter int TABLE_SIZE = 256,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   mode,
    input  wire logic signed [31:0]     coord_x,
    input  wire logic signed [31:0]     coord_y,
    input  wire logic signed [31:0]     coord_z,
    input  wire logic signed [31:0]     coord_t,
    input  wire logic [7:0]             entry_index,
    input  wire logic [7:0]             entry_value,
    output logic                        done,
    output logic signed [FRAC_BITS+2:0] noise_value
);
    import pn4_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int ITEM_W = 1 + PERM_W + 5*IDX_W + 4*FRAC_BITS;
    localparam int QDEPTH = 4;

    logic              push, q_full, q_valid, q_pop;
    logic [ITEM_W-1:0] push_item, head_item;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    assign busy = q_full;

    pn4_front #(
        .FRAC_BITS (FRAC_BITS),
        .IDX_W     (IDX_W),
        .ITEM_W    (ITEM_W)
    ) u_front (
        .start       (start),
        .busy        (q_full),
        .mode        (mode),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .coord_t     (coord_t),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .push        (push),
        .item        (push_item)
    );

    pn4_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_item),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_data (head_item)
    );

    pn4_ram #(
        .WIDTH (PERM_W),
        .DEPTH (TABLE_SIZE)
    ) u_perm (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pn4_back #(
        .FRAC_BITS (FRAC_BITS),
        .IDX_W     (IDX_W),
        .ITEM_W    (ITEM_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .item        (head_item),
        .pop         (q_pop),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .done        (done),
        .noise_value (noise_value)
    );
endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the 4-D gradient noise block.
// ---------------------------------------------------------------------------
// Fills the permutation table, then runs directed and random evaluate and
// load words with bursts of idle on the sending side. A scoreboard
// recomputes every noise value from its own copy of the table and checks
// each done strobe in order against the oldest pending value.
// ---------------------------------------------------------------------------
module tb;
    import pn4_pkg::*;

    localparam int ONE_Q       = 65536;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 150;

    class noise_scoreboard;
        logic [7:0]         perm [256];
        int                 grad_tab [32][4];
        logic signed [18:0] pending_noise [$];
        int                 errors;
        int                 evals_seen;
        int                 loads_seen;

        function new();
            grad_tab = '{
                '{ 1,  1,  1,  0}, '{ 1,  1,  0,  1}, '{ 1,  0,  1,  1}, '{ 0,  1,  1,  1},
                '{ 1,  1, -1,  0}, '{ 1,  1,  0, -1}, '{ 1,  0,  1, -1}, '{ 0,  1,  1, -1},
                '{ 1, -1,  1,  0}, '{ 1, -1,  0,  1}, '{ 1,  0, -1,  1}, '{ 0,  1, -1,  1},
                '{ 1, -1, -1,  0}, '{ 1, -1,  0, -1}, '{ 1,  0, -1, -1}, '{ 0,  1, -1, -1},
                '{-1,  1,  1,  0}, '{-1,  1,  0,  1}, '{-1,  0,  1,  1}, '{ 0, -1,  1,  1},
                '{-1,  1, -1,  0}, '{-1,  1,  0, -1}, '{-1,  0,  1, -1}, '{ 0, -1,  1, -1},
                '{-1, -1,  1,  0}, '{-1, -1,  0,  1}, '{-1,  0, -1,  1}, '{ 0, -1, -1,  1},
                '{-1, -1, -1,  0}, '{-1, -1,  0, -1}, '{-1,  0, -1, -1}, '{ 0, -1, -1, -1}
            };
            errors     = 0;
            evals_seen = 0;
            loads_seen = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function longint fade_weight(longint f);
            longint q2, q3, p;
            q2 = (f * f) >>> 16;
            q3 = (q2 * f) >>> 16;
            p  = 6 * q2 - 15 * f + 10 * ONE_Q;
            return (q3 * p) >>> 16;
        endfunction

        function logic signed [18:0] noise_at(logic [31:0] crd [4]);
            int     cell_idx [4];
            longint offs [4][2];
            longint w [4];
            longint v [16];
            longint r;
            int     h, bit_hi, n;
            for (int a = 0; a < 4; a++)
            begin
                cell_idx[a] = int'(crd[a][23:16]);
                offs[a][0]  = longint'(crd[a][15:0]);
                offs[a][1]  = longint'(crd[a][15:0]) - ONE_Q;
                w[a]        = fade_weight(offs[a][0]);
            end
            for (int c = 0; c < 16; c++)
            begin
                h = 0;
                for (int a = 0; a < 4; a++)
                begin
                    bit_hi = (c >> (3 - a)) & 1;
                    h = int'(perm[(cell_idx[a] + bit_hi + h) & 255]);
                end
                v[c] = 0;
                for (int a = 0; a < 4; a++)
                    v[c] += grad_tab[h & 31][a] * offs[a][(c >> (3 - a)) & 1];
            end
            // collapse along t, z, y, then x
            n = 8;
            for (int a = 3; a >= 0; a--)
            begin
                for (int c = 0; c < n; c++)
                    v[c] = v[2*c] + (((v[2*c+1] - v[2*c]) * w[a]) >>> 16);
                n = n >> 1;
            end
            r = v[0];
            if (r > 3 * ONE_Q)
                r = 3 * ONE_Q;
            if (r < -3 * ONE_Q)
                r = -3 * ONE_Q;
            return r[18:0];
        endfunction

        function void note_word(mode_t m, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z, logic [31:0] t,
                                logic [7:0] idx, logic [7:0] val);
            logic [31:0] crd [4];
            if (m == MODE_LOAD)
            begin
                perm[idx] = val;
                loads_seen++;
            end
            else
            begin
                crd = '{x, y, z, t};
                pending_noise.push_back(noise_at(crd));
                evals_seen++;
            end
        endfunction

        task check_noise(logic [18:0] got);
            logic [18:0] want;
            if (pending_noise.size() == 0)
                report_mismatch($sformatf("unexpected noise_value %h", got));
            else
            begin
                want = pending_noise.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("noise_value %h, want %h", got, want));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               mode;
    logic signed [31:0] coord_x, coord_y, coord_z, coord_t;
    logic [7:0]         entry_index, entry_value;
    logic               done;
    logic signed [18:0] noise_value;

    noise_scoreboard sb;
    int              cycles;
    bit              quiet_sender;

    perlin_noise_4d_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .coord_t     (coord_t),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .done        (done),
        .noise_value (noise_value)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("perlin_noise_4d_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_noise(noise_value);
    end

    // hold the word until the block takes it
    task send_word(mode_t m, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                   logic [31:0] t, logic [7:0] idx, logic [7:0] val);
        start       <= 1'b1;
        mode        <= m;
        coord_x     <= x;
        coord_y     <= y;
        coord_z     <= z;
        coord_t     <= t;
        entry_index <= idx;
        entry_value <= val;
        do
            @(posedge clk);
        while (busy);
        sb.note_word(m, x, y, z, t, idx, val);
    endtask

    task send_eval(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] t);
        send_word(MODE_EVAL, x, y, z, t, 8'($urandom), 8'($urandom));
    endtask

    task send_load(logic [7:0] idx, logic [7:0] val);
        send_word(MODE_LOAD, $urandom, $urandom, $urandom, $urandom, idx, val);
    endtask

    task maybe_idle();
        if (!quiet_sender && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    function logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
            2: return {16'($urandom), 16'hffff};
            default: return {16'($urandom), 16'h0000} | 32'($urandom_range(0, 3));
        endcase
    endfunction

    initial
    begin
        logic [7:0] shuffle [256];
        logic [7:0] tmp;
        int         j;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        mode         = MODE_EVAL;
        coord_x      = '0;
        coord_y      = '0;
        coord_z      = '0;
        coord_t      = '0;
        entry_index  = '0;
        entry_value  = '0;
        cycles       = 0;
        quiet_sender = 1'b0;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the table with a shuffled permutation
        for (int i = 0; i < 256; i++)
            shuffle[i] = 8'(i);
        for (int i = 255; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = shuffle[i];
            shuffle[i] = shuffle[j];
            shuffle[j] = tmp;
        end
        for (int i = 0; i < 256; i++)
        begin
            send_load(8'(i), shuffle[i]);
            maybe_idle();
        end

        // directed: extremes, cell wrap, fraction edges
        send_eval(32'h0, 32'h0, 32'h0, 32'h0);
        send_eval(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_eval(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_eval(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0);
        send_eval(32'h00ff_8000, 32'h00ff_ffff, 32'hff00_0001, 32'h0100_0000);
        send_eval(32'h0001_0000, 32'hfffe_0000, 32'h0000_8000, 32'hffff_8000);
        send_eval(32'h0000_0001, 32'h0000_ffff, 32'hffff_0001, 32'h1234_5678);
        send_load(8'h00, 8'hff);
        send_load(8'hff, 8'h00);
        send_eval(32'h00ff_4000, 32'h00ff_c000, 32'h0000_4000, 32'h00ff_2000);
        send_load(8'h80, 8'h7f);
        send_eval(32'hff80_3000, 32'h007f_9000, 32'hff7f_1000, 32'h0080_e000);
        maybe_idle();

        // drain everything before the random part
        start <= 1'b0;
        while (sb.pending_noise.size() != 0)
            @(posedge clk);

        for (int i = 0; i < 660; i++)
        begin
            if (i >= 510)
                quiet_sender = 1'b1;
            if ($urandom_range(0, 7) == 0)
                send_load(8'($urandom), 8'($urandom));
            else
                send_eval(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            maybe_idle();
        end

        start <= 1'b0;
        while (sb.pending_noise.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d evaluations and %0d table loads in %0d cycles.",
                 sb.evals_seen, sb.loads_seen, cycles);
        if (sb.pending_noise.size() != 0)
            sb.report_mismatch($sformatf("%0d noise values never came",
                                         sb.pending_noise.size()));
        if (sb.errors == 0)
            $display("perlin_noise_4d_top test passed");
        else
            $display("perlin_noise_4d_top test failed");
        $finish;
    end
endmodule
